### sv/kdm_pkg.sv
// ----------------------------------------------------------------------------
// kdm_pkg
// Types, sizes and keymap ROM shared by the key debounce / macro sequencer.
// ----------------------------------------------------------------------------
package kdm_pkg;

  localparam int NUM_KEYS     = 12;
  localparam int FIFO_DEPTH   = 16;
  localparam int MAX_CHORDS   = 2;
  localparam int ROM_KEYS     = 12;
  localparam int ROM_CHORDS   = 2;
  localparam int KEY_W        = 4;
  localparam int CNT_W        = 4;
  localparam int KEY_IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int CHORD_W      = $clog2(MAX_CHORDS + 1);
  localparam logic [CNT_W-1:0] STABLE_SCANS_RESET = 4'd5;
  localparam logic [7:0] SHIFT_L = 8'h02;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key_num;
    logic             pressed;
    logic             host_ready;
    logic             report_accepted;
  } req_t;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] keycode;
    logic       is_release;
    logic       macro_done;
  } rpt_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic             is_sample;   // sample of an existing key
    logic             is_slot;     // report slot with host ready
    logic [KEY_W-1:0] key;
    logic             level;
    logic             accepted;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } evt_push_t;

  function automatic logic [7:0] rom_modifier(input logic [KEY_W-1:0] key,
                                              input logic [CHORD_W-1:0] chord);
    logic [7:0] m;
    m = 8'h00;
    if (chord == '0) begin
      case (key)
        4'd5, 4'd7: m = SHIFT_L;
        default:    m = 8'h00;
      endcase
    end
    return m;
  endfunction

  function automatic logic [7:0] rom_keycode(input logic [KEY_W-1:0] key,
                                             input logic [CHORD_W-1:0] chord);
    logic [7:0] c;
    c = 8'h00;
    if (chord == '0) begin
      case (key)
        4'd0:       c = 8'h29;
        4'd1:       c = 8'h0C;
        4'd2:       c = 8'h0E;
        4'd3:       c = 8'h0D;
        4'd4:       c = 8'h27;
        4'd5:       c = 8'h21;
        4'd6, 4'd7: c = 8'h1A;
        4'd8:       c = 8'h24;
        4'd9:       c = 8'h1E;
        4'd10:      c = 8'h1B;
        4'd11:      c = 8'h07;
        default:    c = 8'h00;
      endcase
    end else if (CHORD_W'(1) == chord) begin
      case (key)
        4'd9:    c = 8'h20;
        4'd11:   c = 8'h1A;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  // chord count of a macro, limited to MAX_CHORDS; unknown keys play one chord
  function automatic logic [CHORD_W-1:0] chords_of(input logic [KEY_W-1:0] key);
    logic [CHORD_W-1:0] n;
    case (key)
      4'd9, 4'd11: n = CHORD_W'(2);
      default:     n = CHORD_W'(1);
    endcase
    if (n > CHORD_W'(MAX_CHORDS)) n = CHORD_W'(MAX_CHORDS);
    return n;
  endfunction

endpackage

### sv/kdm_front.sv
// ----------------------------------------------------------------------------
// kdm_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module kdm_front (
  input  logic          clk,
  input  logic          rst,
  input  kdm_pkg::req_t request,
  input  logic          push,
  output logic          full,
  output kdm_pkg::cmd_t head,
  output logic          head_valid,
  input  logic          head_take
);
  import kdm_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  cmd_t       cls;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    cls.is_sample = !request.command && (KEY_W'(NUM_KEYS) > request.key_num);
    cls.is_slot   = request.command && request.host_ready;
    cls.key       = request.key_num;
    cls.level     = request.pressed;
    cls.accepted  = request.report_accepted;
  end

  assign full       = (cnt == 2'd2);
  assign head_valid = (cnt != 2'd0);
  assign head       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) q[wr_ptr] <= cls;
  end

endmodule

### sv/kdm_debounce.sv
// ----------------------------------------------------------------------------
// kdm_debounce
// Per-key raw level, stability count and debounced level; flags new presses.
// ----------------------------------------------------------------------------
module kdm_debounce (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  kdm_pkg::cmd_t            cmd,
  input  logic [kdm_pkg::CNT_W-1:0] stable_scans,
  output kdm_pkg::evt_push_t       evt
);
  import kdm_pkg::*;

  logic [NUM_KEYS-1:0] raw_level;
  logic [NUM_KEYS-1:0] clean_level;
  logic [CNT_W-1:0]    stable_count [NUM_KEYS];

  logic [KEY_IDX_W-1:0] idx;
  logic [CNT_W-1:0]     cnt_next;
  logic                 take;
  logic                 act;

  assign idx = cmd.key[KEY_IDX_W-1:0];
  assign act = fire && cmd.is_sample;

  always_comb begin
    if (cmd.level != raw_level[idx]) cnt_next = CNT_W'(1);
    else if (stable_count[idx] < stable_scans) cnt_next = stable_count[idx] + CNT_W'(1);
    else cnt_next = stable_count[idx];
    take = !(cnt_next < stable_scans) && (clean_level[idx] != cmd.level);
  end

  assign evt.valid = act && take && cmd.level;
  assign evt.key   = cmd.key;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level   <= '0;
      clean_level <= '0;
      for (int i = 0; i < NUM_KEYS; i++) stable_count[i] <= '0;
    end else if (act) begin
      raw_level[idx]    <= cmd.level;
      stable_count[idx] <= cnt_next;
      if (take) clean_level[idx] <= cmd.level;
    end
  end

endmodule

### sv/kdm_player.sv
// ----------------------------------------------------------------------------
// kdm_player
// Key event ring FIFO, macro playback sequencer and two-entry report queue.
// ----------------------------------------------------------------------------
module kdm_player (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  kdm_pkg::cmd_t      cmd,
  input  kdm_pkg::evt_push_t evt,
  output logic               busy,
  output kdm_pkg::rpt_t      report,
  output logic               empty,
  input  logic               pop
);
  import kdm_pkg::*;

  logic [KEY_W-1:0] event_fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] read_pointer;
  logic             macro_active;
  logic [KEY_W-1:0] current_macro;
  logic [CHORD_W-1:0] current_chord;
  logic             awaiting_release;

  logic [KEY_W-1:0]   macro_next;
  logic [CHORD_W-1:0] chord_next;
  logic [CHORD_W-1:0] chord_inc;
  logic [CHORD_W-1:0] count;
  logic               active_next;
  logic               await_next;
  logic               rd_adv;
  logic               slot;
  logic               res_valid;
  rpt_t               res;

  rpt_t       oq [2];
  logic       oq_wr;
  logic       oq_rd;
  logic [1:0] oq_cnt;
  logic       do_pop;

  logic [PTR_W-1:0] wp_inc;
  assign wp_inc = write_pointer + PTR_W'(1);

  assign slot = fire && cmd.is_slot;

  always_comb begin
    macro_next  = current_macro;
    chord_next  = current_chord;
    active_next = macro_active;
    await_next  = awaiting_release;
    rd_adv      = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    if (!macro_active && (read_pointer != write_pointer)) begin
      macro_next  = event_fifo[read_pointer];
      rd_adv      = 1'b1;
      active_next = 1'b1;
      chord_next  = '0;
      await_next  = 1'b0;
    end
    count     = chords_of(macro_next);
    chord_inc = chord_next + CHORD_W'(1);
    if (active_next) begin
      res_valid = 1'b1;
      if (!await_next) begin
        if (KEY_W'(ROM_KEYS) > macro_next && CHORD_W'(ROM_CHORDS) > chord_next) begin
          res.modifier = rom_modifier(macro_next, chord_next);
          res.keycode  = rom_keycode(macro_next, chord_next);
        end
        if (cmd.accepted) await_next = 1'b1;
      end else begin
        res.is_release = 1'b1;
        res.macro_done = cmd.accepted && (chord_inc >= count);
        if (cmd.accepted) begin
          await_next = 1'b0;
          chord_next = chord_inc;
          if (chord_inc >= count) begin
            active_next = 1'b0;
            chord_next  = '0;
          end
        end
      end
    end
  end

  assign busy   = (oq_cnt == 2'd2);
  assign empty  = (oq_cnt == 2'd0);
  assign report = oq[oq_rd];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer    <= '0;
      read_pointer     <= '0;
      macro_active     <= 1'b0;
      current_macro    <= '0;
      current_chord    <= '0;
      awaiting_release <= 1'b0;
      oq_wr            <= 1'b0;
      oq_rd            <= 1'b0;
      oq_cnt           <= 2'd0;
    end else begin
      // new press is dropped when the ring holds FIFO_DEPTH-1 entries
      if (evt.valid && (wp_inc != read_pointer)) write_pointer <= wp_inc;
      if (slot) begin
        if (rd_adv) read_pointer <= read_pointer + PTR_W'(1);
        macro_active     <= active_next;
        current_macro    <= macro_next;
        current_chord    <= chord_next;
        awaiting_release <= await_next;
      end
      if (slot && res_valid) oq_wr <= !oq_wr;
      if (do_pop) oq_rd <= !oq_rd;
      oq_cnt <= oq_cnt + {1'b0, slot && res_valid} - {1'b0, do_pop};
    end
    if (evt.valid && (wp_inc != read_pointer)) event_fifo[write_pointer] <= evt.key;
    if (slot && res_valid) oq[oq_wr] <= res;
  end

endmodule

### sv/key_debounce_macro_report_sequencer.sv
// A report is written into the two-entry report queue when its slot is accepted.
// The block takes 1 item per cycle while the report queue is not full; each item is
// a read-modify-write of the per-key registers, the event ring and the macro state.
// Both sides have 2-entry queues, so either side may stall on its own.
// Reset (synchronous, rst high) clears all key state, pointers and queues.
// ----------------------------------------------------------------------------
// key_debounce_macro_report_sequencer
// Debounces key samples, queues presses and plays keymap macros as reports.
// ----------------------------------------------------------------------------
module key_debounce_macro_report_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  input  kdm_pkg::req_t             request,
  input  logic                      push,
  output logic                      full,
  output kdm_pkg::rpt_t             report,
  output logic                      empty,
  input  logic                      pop,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [kdm_pkg::CNT_W-1:0] cfg_data
);
  import kdm_pkg::*;

  logic             cfg_write;
  logic [CNT_W-1:0] scans;
  cmd_t             head;
  logic             head_valid;
  logic             back_busy;
  logic             fire;
  evt_push_t        evt;

  assign cfg_ready = 1'b1;
  assign fire      = head_valid && !back_busy;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) scans <= STABLE_SCANS_RESET;
    else if (cfg_write) scans <= cfg_data;
  end

  kdm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .push       (push),
    .full       (full),
    .head       (head),
    .head_valid (head_valid),
    .head_take  (fire)
  );

  kdm_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .cmd          (head),
    .stable_scans (scans),
    .evt          (evt)
  );

  kdm_player u_player (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .cmd    (head),
    .evt    (evt),
    .busy   (back_busy),
    .report (report),
    .empty  (empty),
    .pop    (pop)
  );

endmodule
